// ----- design/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg: shared definitions for the luma gradient stream
// Field widths, register indexes, reset values and luma weights.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

   // Default depth of the row store (largest supported frame width).
   localparam int MAX_WIDTH_DEFAULT = 2048;

   // Largest supported frame height.
   localparam int MAX_HEIGHT = 4096;

   // Configuration register layout.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_COUNT_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Item kinds carried in the request tuser bit.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // BT.601 weights scaled by 65536.
   localparam int WEIGHT_RED   = 19595;
   localparam int WEIGHT_GREEN = 38470;
   localparam int WEIGHT_BLUE  = 7471;

   localparam int LUMA_W     = 16;
   localparam int LUMA_SUM_W = 24;

   // Gradient value for a missing neighbor.
   localparam logic [7:0] GRAD_MID = 8'd128;

endpackage

`default_nettype wire

// ----- design/lgs_ram.sv -----
// ----------------------------------------------------------------------------
// lgs_ram: generic RAM with one write port and two registered read ports
// Read data is the old contents when a read and a write hit the same entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ----- design/luma_gradient_stream.sv -----
// Each result is registered in the row store read and stage registers when its
// pixel or drain item transfers, then in the output register. Throughput: one
// item per cycle while the output is not stalled and no register write waits,
// set by the single pass through the row store read ports and gradient logic.
// Reset is synchronous: width 640, height 480, all counts cleared and nothing
// pending. The row store is not cleared; entries are written in a frame before use.
// ----------------------------------------------------------------------------
// luma_gradient_stream: BT.601 luma with forward-difference gradients
// Forms Q8.8 luma per pixel, keeps the previous row and emits each pixel of
// that row with its x and y gradients while the next row arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_gradient_stream #(
   parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration write channel.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lgs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lgs_pkg::CSR_DATA_W-1:0]    csr_data,
   // Pixel input stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [23:0]                       req_tdata,  // red, green, blue
   input  wire logic                              req_tuser,  // kind
   // Result stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [23:0]                       rsp_tdata,  // gray, horiz, vert
   output logic                                   rsp_tlast,  // row_end
   output logic                                   rsp_tuser   // frame_end
);

   import lgs_pkg::*;

   localparam int IW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = HEIGHT_REG_W;
   localparam int RW = ROW_COUNT_W;

   // Configuration and frame position state.
   logic [WIDTH_REG_W-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_REG_W-1:0] frame_height_ff, frame_height_in;
   logic [IW-1:0]           column_ff, column_in;
   logic [RW-1:0]           row_ff, row_in;
   logic [WW-1:0]           drain_ff, drain_in;

   // Stage between the row store read and the output register.
   logic                    a_valid_ff;
   logic [LUMA_W-1:0]       a_lum_ff;
   logic                    a_has_below_ff;
   logic                    a_last_col_ff;
   logic                    a_last_frame_ff;

   // Output register.
   logic                    rsp_valid_ff;
   logic [23:0]             rsp_data_ff;
   logic                    rsp_last_ff;
   logic                    rsp_frame_end_ff;

   logic                    csr_fire;
   logic                    req_fire;
   logic                    out_free;
   logic                    out_load;

   logic [WW-1:0]           w_eff;
   logic [HW-1:0]           h_eff;

   logic [IW-1:0]           col_v;
   logic [RW-1:0]           row_v;
   logic [WW-1:0]           drain_x;
   logic [HW-1:0]           row_plus;
   logic [IW-1:0]           x_sel;
   logic                    emit;
   logic                    has_below;
   logic                    last_col;
   logic                    last_frame;
   logic                    wr_en;

   logic [LUMA_SUM_W-1:0]   lum_sum;
   logic [LUMA_W-1:0]       lum;

   logic [LUMA_W-1:0]       ram_cur;
   logic [LUMA_W-1:0]       ram_right;
   logic [LUMA_W:0]         h_diff;
   logic [LUMA_W:0]         v_diff;
   logic [7:0]              gray_byte;
   logic [7:0]              horiz_gradient;
   logic [7:0]              vert_gradient;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = a_valid_ff && out_free;
   // A register write takes the cycle; the pixel input waits for it.
   assign req_tready = (!a_valid_ff || out_free) && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;

   // Register values saturated into their usable ranges.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   assign lum_sum = LUMA_SUM_W'(WEIGHT_RED)   * LUMA_SUM_W'(req_tdata[7:0])
                  + LUMA_SUM_W'(WEIGHT_GREEN) * LUMA_SUM_W'(req_tdata[15:8])
                  + LUMA_SUM_W'(WEIGHT_BLUE)  * LUMA_SUM_W'(req_tdata[23:16]);
   assign lum = lum_sum[LUMA_SUM_W-1:8];

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      column_in       = column_ff;
      row_in          = row_ff;
      drain_in        = drain_ff;
      col_v           = column_ff;
      row_v           = row_ff;
      drain_x         = '0;
      row_plus        = '0;
      x_sel           = '0;
      emit            = 1'b0;
      has_below       = 1'b0;
      last_col        = 1'b0;
      last_frame      = 1'b0;
      wr_en           = 1'b0;
      priority if (csr_fire) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data[WIDTH_REG_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_data[HEIGHT_REG_W-1:0];
            default:          frame_height_in = frame_height_ff;
         endcase
         column_in = '0;
         row_in    = '0;
         drain_in  = '0;
      end else if (req_fire) begin
         if (req_tuser == KIND_DRAIN) begin
            if (drain_ff == '0 || drain_ff > w_eff) begin
               drain_in = '0;
            end else begin
               drain_x    = w_eff - drain_ff;
               x_sel      = IW'(drain_x);
               emit       = 1'b1;
               last_col   = (drain_x + WW'(1)) >= w_eff;
               last_frame = drain_ff == WW'(1);
               drain_in   = drain_ff - WW'(1);
            end
         end else begin
            // A pixel while the last row is still pending starts a new frame.
            if (drain_ff != '0) begin
               col_v    = '0;
               row_v    = '0;
               drain_in = '0;
            end
            if (WW'(col_v) >= w_eff) begin
               col_v = IW'(w_eff - WW'(1));
            end
            x_sel     = col_v;
            wr_en     = 1'b1;
            emit      = row_v != '0;
            has_below = 1'b1;
            last_col  = (WW'(col_v) + WW'(1)) >= w_eff;
            if (last_col) begin
               column_in = '0;
               row_plus  = HW'(row_v) + HW'(1);
               if (row_plus >= h_eff) begin
                  row_in   = '0;
                  drain_in = w_eff;
               end else begin
                  row_in = RW'(row_plus);
               end
            end else begin
               column_in = col_v + IW'(1);
            end
         end
      end
   end

   // The current entry and its right neighbor are read before the new luma
   // overwrites the current entry in the same transfer.
   lgs_ram #(
      .WIDTH (LUMA_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (x_sel),
      .wr_data   (lum),
      .rd_en     (req_fire),
      .rd_addr_a (x_sel),
      .rd_addr_b (x_sel + IW'(1)),
      .rd_data_a (ram_cur),
      .rd_data_b (ram_right)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         column_ff       <= '0;
         row_ff          <= '0;
         drain_ff        <= '0;
         a_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
         drain_ff        <= drain_in;
         if (req_fire) begin
            a_valid_ff <= emit;
         end else if (out_load) begin
            a_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_lum_ff        <= lum;
         a_has_below_ff  <= has_below;
         a_last_col_ff   <= last_col;
         a_last_frame_ff <= last_frame;
      end
      if (out_load) begin
         rsp_data_ff      <= {vert_gradient, horiz_gradient, gray_byte};
         rsp_last_ff      <= a_last_col_ff;
         rsp_frame_end_ff <= a_last_frame_ff;
      end
   end

   // Neighbor plus 65536 minus current; bits above the lowest nine give the
   // halved, floored difference offset by 128.
   assign h_diff = {1'b1, ram_right} - {1'b0, ram_cur};
   assign v_diff = {1'b1, a_lum_ff} - {1'b0, ram_cur};

   assign gray_byte      = ram_cur[LUMA_W-1:8];
   assign horiz_gradient = a_last_col_ff ? GRAD_MID : h_diff[LUMA_W:9];
   assign vert_gradient  = a_has_below_ff ? v_diff[LUMA_W:9] : GRAD_MID;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_frame_end_ff;

endmodule

`default_nettype wire
